/* src/lph_pkg.sv */
// Package: shared types, constants and helpers of the linear probe hash table.
package lph_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int SIZE_W   = 5;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(5);

    // Hash word is 3*key+5, padded to a whole number of four-bit digits.
    localparam int HASH_W      = KEY_W + 2;
    localparam int DIGIT_W     = 4;
    localparam int HASH_DIGITS = (HASH_W + DIGIT_W - 1) / DIGIT_W;
    localparam int HASH_PAD_W  = HASH_DIGITS * DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(HASH_DIGITS);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        TAG_EMPTY   = 2'd0,
        TAG_USED    = 2'd1,
        TAG_DELETED = 2'd2
    } tag_t;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] key;
    } item_t;

    typedef struct packed {
        logic               success;
        logic [3:0]         slot;
        logic [COUNT_W-1:0] live_count;
    } result_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] home;
    } job_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_HASH,
        FR_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_DONE
    } back_state_t;

    // Number of slots in use: zero counts as one, large values saturate.
    function automatic logic [SIZE_W:0] active_size(input logic [SIZE_W-1:0] size);
        logic [SIZE_W:0] n;
        begin
            n = {1'b0, size};
            if (size == '0)
            begin
                n = (SIZE_W+1)'(1);
            end
            else if (n > (SIZE_W+1)'(CAPACITY))
            begin
                n = (SIZE_W+1)'(CAPACITY);
            end
            return n;
        end
    endfunction

endpackage

/* src/lph_front.sv */
// Front end: accepts items and reduces each key's hash to its home slot.
module lph_front
    import lph_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  item_t             item,
    input  logic [SIZE_W:0]   n,
    output logic              job_valid,
    input  logic              job_ready,
    output job_t              job
);

    front_state_t            state_reg, state_next;
    logic [HASH_PAD_W-1:0]   hash_reg;
    logic [SIZE_W-1:0]       rem_reg, rem_step;
    logic [DIGIT_CNT_W-1:0]  digit_reg;
    item_t                   item_reg;

    // One four-bit digit a cycle: remainder stays below n, so each bit needs one compare.
    always_comb
    begin
        logic [SIZE_W:0] r;
        r = {1'b0, rem_reg};
        for (int k = 0; k < DIGIT_W; k++)
        begin
            r = {r[SIZE_W-1:0], hash_reg[HASH_PAD_W-1-k]};
            if (r >= n)
            begin
                r = r - n;
            end
        end
        rem_step = r[SIZE_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE:
            begin
                if (push)
                begin
                    state_next = FR_HASH;
                end
            end
            FR_HASH:
            begin
                if (digit_reg == DIGIT_CNT_W'(HASH_DIGITS - 1))
                begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                if (job_ready)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        full      = (state_reg != FR_IDLE);
        job_valid = (state_reg == FR_PUSH);
        job.operation = item_reg.operation;
        job.key       = item_reg.key;
        job.home      = rem_reg[SLOT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == FR_IDLE && push)
        begin
            item_reg  <= item;
            hash_reg  <= HASH_PAD_W'({2'b00, item.key} * 3 + 5);
            rem_reg   <= '0;
            digit_reg <= '0;
        end
        else if (state_reg == FR_HASH)
        begin
            rem_reg   <= rem_step;
            hash_reg  <= {hash_reg[HASH_PAD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            digit_reg <= digit_reg + 1'b1;
        end
    end

endmodule

/* src/lph_queue.sv */
// Two-entry queue of hashed jobs between the front end and the probe engine.
module lph_queue
    import lph_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_job,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_job
);

    job_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic       do_wr, do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_job   = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_job;
        end
    end

endmodule

/* src/lph_back.sv */
// Probe engine: holds the slots, walks the probe sequence and forms results.
module lph_back
    import lph_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [SIZE_W:0] n,
    input  logic            job_valid,
    output logic            job_ready,
    input  job_t            job,
    output logic            empty,
    input  logic            pop,
    output result_t         result
);

    back_state_t        state_reg, state_next;
    tag_t               tag_reg [CAPACITY];
    logic [KEY_W-1:0]   key_mem [CAPACITY];
    logic [COUNT_W-1:0] count_reg;
    logic [1:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [SLOT_W-1:0]  d_reg, i_reg;
    tag_t               tag_rd_reg;
    logic [KEY_W-1:0]   key_rd_reg;
    logic               ok_reg;
    logic [SLOT_W-1:0]  where_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    logic found, stop, last, out_free;

    assign last     = ({1'b0, i_reg} == SIZE_W'(n - 1'b1));
    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        if (op_reg == OP_INSERT)
        begin
            found = (tag_rd_reg != TAG_USED);
            stop  = found || last;
        end
        else
        begin
            found = (tag_rd_reg == TAG_USED) && (key_rd_reg == key_reg);
            stop  = found || last || (tag_rd_reg == TAG_EMPTY);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = (job.operation == OP_CLEAR) ? BK_DONE : BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_CHECK;
            end
            BK_CHECK:
            begin
                state_next = stop ? BK_DONE : BK_READ;
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        job_ready = (state_reg == BK_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < CAPACITY; s++)
            begin
                tag_reg[s] <= TAG_EMPTY;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_IDLE && job_valid && job.operation == OP_CLEAR)
            begin
                count_reg <= '0;
                for (int s = 0; s < CAPACITY; s++)
                begin
                    tag_reg[s] <= TAG_EMPTY;
                end
            end
            else if (state_reg == BK_CHECK && found)
            begin
                if (op_reg == OP_INSERT)
                begin
                    tag_reg[d_reg] <= TAG_USED;
                    count_reg      <= count_reg + 1'b1;
                end
                else if (op_reg == OP_DELETE)
                begin
                    tag_reg[d_reg] <= TAG_DELETED;
                    if (count_reg != '0)
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                end
            end
            if (state_reg == BK_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_CHECK && found && op_reg == OP_INSERT)
        begin
            key_mem[d_reg] <= key_reg;
        end
        if (state_reg == BK_READ)
        begin
            key_rd_reg <= key_mem[d_reg];
            tag_rd_reg <= tag_reg[d_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                op_reg    <= job.operation;
                key_reg   <= job.key;
                d_reg     <= job.home;
                i_reg     <= '0;
                ok_reg    <= (job.operation == OP_CLEAR);
                where_reg <= '0;
            end
            BK_CHECK:
            begin
                if (found)
                begin
                    ok_reg    <= 1'b1;
                    where_reg <= d_reg;
                end
                else if (!stop)
                begin
                    i_reg <= i_reg + 1'b1;
                    d_reg <= ({1'b0, d_reg} + 1'b1 == SIZE_W'(n)) ? '0 : d_reg + 1'b1;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    out_reg.success    <= ok_reg;
                    out_reg.slot       <= 4'(where_reg);
                    out_reg.live_count <= count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* src/linear_probe_hash_table_core.sv */
// Top level: open-addressing hash table with linear probing and tombstones.
//
// Each transfer on the item side carries an operation (insert, search, delete
// or clear) and a 32-bit key, and yields exactly one result transfer holding
// a success flag, the slot touched and the live-entry count afterwards. The
// front end reduces 3*key+5 modulo the active table size four bits per
// cycle, one per digit of the nine-digit hash word, then hands the job on. A
// two-entry queue then feeds the probe engine, which for each probed slot
// first reads the slot's key and tag and then compares them, probing from one
// slot up to the active size before it posts the result; clear skips the
// probe. The front end hashes the next item while the engine probes, and a
// finished result waits in the output register without blocking new items.
// The table_size register is written through the cfg channel, which is always
// ready; write it only while the block is idle. A size of zero acts as one
// slot and sizes above sixteen act as sixteen.
module linear_probe_hash_table_core
    import lph_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  item_t             item,
    output logic              empty,
    input  logic              pop,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data
);

    logic [SIZE_W-1:0] table_size_reg;
    logic [SIZE_W:0]   n;

    // Front end to queue, and queue to probe engine.
    logic job_valid, job_ready, bk_valid, bk_ready;
    job_t job, bk_job;

    assign cfg_ready = 1'b1;
    assign n         = active_size(table_size_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            table_size_reg <= cfg_data;
        end
    end

    lph_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .n         (n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    lph_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (job_valid),
        .wr_ready (job_ready),
        .wr_job   (job),
        .rd_valid (bk_valid),
        .rd_ready (bk_ready),
        .rd_job   (bk_job)
    );

    lph_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .n         (n),
        .job_valid (bk_valid),
        .job_ready (bk_ready),
        .job       (bk_job),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
